### rtl/pbff_pkg.sv
// Shared types and constants for the first-fit palette builder.
package pbff_pkg;

  localparam int MAX_ENTRIES = 256;
  localparam int ADDR_W      = $clog2(MAX_ENTRIES);
  localparam int CNT_W       = ADDR_W + 1;
  localparam int CHAN_W      = 8;
  localparam int KEY_W       = 3 * CHAN_W;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 9;

  localparam logic [CFG_IDX_W-1:0] REG_NUM_ENTRIES = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_USE_MASK    = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DEFAULT_STP = 2'd2;

  localparam logic [CHAN_W-1:0] BLACK_BLUE = 8'd1;

  typedef struct packed {
    logic [CHAN_W-1:0] red;
    logic [CHAN_W-1:0] green;
    logic [CHAN_W-1:0] blue;
    logic              mask_bit;
    logic              first_pixel;
  } in_t;

  typedef struct packed {
    logic [ADDR_W-1:0] color_index;
    logic              is_new;
    logic [CHAN_W-1:0] entry_red;
    logic [CHAN_W-1:0] entry_green;
    logic [CHAN_W-1:0] entry_blue;
    logic              entry_stp;
    logic              table_full;
  } out_t;

  // controller -> datapath
  typedef struct packed {
    logic capture;
    logic step;
    logic finish;
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic hit;
    logic scan_done;
  } stat_t;

endpackage

### rtl/palette_builder_first_fit.sv
// Search: a miss loads its result once all S stored keys (S = min(filled entries, size))
// are compared, a hit on entry j once entry j has been compared. Throughput: one pixel
// at a time, one stored key per cycle from the single read port of the key memory; the
// next pixel is accepted on the edge after the result loads. A stalled output holds back
// only the result load.
// Reset (rst_n, synchronous, active low) empties the table, restores size 16, mask off, stp 0.
module palette_builder_first_fit (
  input  logic                            clk,
  input  logic                            rst_n,
  // configuration writes
  input  logic                            cfg_we,
  input  logic [pbff_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [pbff_pkg::CFG_DATA_W-1:0] cfg_wdata,
  // pixel requests
  input  logic                            in_valid,
  output logic                            in_stall,
  input  pbff_pkg::in_t                   in_data,
  // result requests
  output logic                            out_valid,
  input  logic                            out_stall,
  output pbff_pkg::out_t                  out_data
);

  pbff_pkg::cmd_t  cmd;
  pbff_pkg::stat_t stat;

  // Controller: accepts a pixel, steps the scan until a key matches or all
  // searched entries are compared, then loads the result once the output is free.
  pbff_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath: registers, key memory with a registered read, one compare per
  // cycle, and the new-entry write at the end of a missed search while the table has room.
  pbff_dp u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_wdata (cfg_wdata),
    .in_data   (in_data),
    .cmd       (cmd),
    .stat      (stat),
    .out_data  (out_data)
  );

endmodule

### rtl/pbff_ctrl.sv
// Controller for the palette builder: request handshakes and search sequencing.
module pbff_ctrl (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  output logic            out_valid,
  input  logic            out_stall,
  input  pbff_pkg::stat_t stat,
  output pbff_pkg::cmd_t  cmd
);

  typedef enum logic {
    ST_IDLE,
    ST_SEARCH
  } state_t;

  state_t state_r, state_nxt;
  logic   in_stall_r, in_stall_nxt;
  logic   out_valid_r, out_valid_nxt;
  logic   out_free;
  logic   search_end;

  assign out_free   = !out_valid_r || !out_stall;
  assign search_end = stat.hit || stat.scan_done;

  always_comb begin
    cmd.capture = 1'b0;
    cmd.step    = 1'b0;
    cmd.finish  = 1'b0;
    state_nxt     = state_r;
    in_stall_nxt  = in_stall_r;
    out_valid_nxt = out_valid_r && out_stall;
    case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.capture  = 1'b1;
          in_stall_nxt = 1'b1;
          state_nxt    = ST_SEARCH;
        end
      end
      ST_SEARCH: begin
        if (!search_end) begin
          cmd.step = 1'b1;
        end else if (out_free) begin
          cmd.finish    = 1'b1;
          out_valid_nxt = 1'b1;
          in_stall_nxt  = 1'b0;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt    = ST_IDLE;
        in_stall_nxt = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      in_stall_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      in_stall_r  <= in_stall_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign in_stall  = in_stall_r;
  assign out_valid = out_valid_r;

  a_finish_sets_valid: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish |=> out_valid_r)
    else $error("result not presented after finish");

  a_stall_while_busy: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.capture |=> in_stall_r && state_r == ST_SEARCH)
    else $error("input not held off during search");

  a_no_step_at_end: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step |-> !stat.hit && !stat.scan_done)
    else $error("search advanced past its end");

endmodule

### rtl/pbff_dp.sv
// Datapath for the palette builder: config, color key memory, compare and result register.
module pbff_dp (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  logic                                 cfg_we,
  input  logic [pbff_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [pbff_pkg::CFG_DATA_W-1:0]      cfg_wdata,
  input  pbff_pkg::in_t                        in_data,
  input  pbff_pkg::cmd_t                       cmd,
  output pbff_pkg::stat_t                      stat,
  output pbff_pkg::out_t                       out_data
);

  logic [pbff_pkg::CFG_DATA_W-1:0] num_entries_r;
  logic                            use_mask_r;
  logic                            default_stp_r;

  logic [pbff_pkg::KEY_W-1:0]  mem [pbff_pkg::MAX_ENTRIES];

  logic [pbff_pkg::KEY_W-1:0]  key_r;
  logic                        mbit_r;
  logic [pbff_pkg::CNT_W-1:0]  fill_r;
  logic [pbff_pkg::CNT_W-1:0]  addr_r;
  logic [pbff_pkg::KEY_W-1:0]  rdata_r;
  logic                        cmp_v_r;
  logic [pbff_pkg::ADDR_W-1:0] cmp_idx_r;
  pbff_pkg::out_t              res_r, res_nxt;

  logic [pbff_pkg::CNT_W-1:0]  limit;
  logic [pbff_pkg::CNT_W-1:0]  searched;
  logic                        rd_en;
  logic                        hit;
  logic                        room;

  assign limit    = (num_entries_r > pbff_pkg::CNT_W'(pbff_pkg::MAX_ENTRIES))
                  ? pbff_pkg::CNT_W'(pbff_pkg::MAX_ENTRIES) : num_entries_r;
  assign searched = (fill_r < limit) ? fill_r : limit;
  assign rd_en    = addr_r < searched;
  assign hit      = cmp_v_r && (rdata_r == key_r);
  assign room     = fill_r < limit;

  assign stat.hit       = hit;
  assign stat.scan_done = !rd_en && !cmp_v_r;

  // config registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_entries_r <= pbff_pkg::CFG_DATA_W'(16);
      use_mask_r    <= 1'b0;
      default_stp_r <= 1'b0;
    end else if (cfg_we) begin
      case (cfg_index)
        pbff_pkg::REG_NUM_ENTRIES: num_entries_r <= cfg_wdata;
        pbff_pkg::REG_USE_MASK:    use_mask_r    <= cfg_wdata[0];
        pbff_pkg::REG_DEFAULT_STP: default_stp_r <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  // result for the current pixel
  always_comb begin
    res_nxt = '0;
    if (hit) begin
      res_nxt.color_index = cmp_idx_r;
    end else if (room) begin
      res_nxt.color_index = fill_r[pbff_pkg::ADDR_W-1:0];
      res_nxt.is_new      = 1'b1;
      res_nxt.entry_red   = key_r[2*pbff_pkg::CHAN_W +: pbff_pkg::CHAN_W];
      res_nxt.entry_green = key_r[pbff_pkg::CHAN_W +: pbff_pkg::CHAN_W];
      res_nxt.entry_blue  = (key_r == '0) ? pbff_pkg::BLACK_BLUE
                          : key_r[0 +: pbff_pkg::CHAN_W];
      res_nxt.entry_stp   = use_mask_r ? mbit_r : default_stp_r;
    end else begin
      res_nxt.table_full = 1'b1;
    end
  end

  // key memory: one read port for the scan, one write for a new entry
  always_ff @(posedge clk) begin
    if (cmd.step && rd_en) begin
      rdata_r <= mem[addr_r[pbff_pkg::ADDR_W-1:0]];
    end
    if (cmd.finish && !hit && room) begin
      mem[fill_r[pbff_pkg::ADDR_W-1:0]] <= key_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fill_r  <= '0;
      addr_r  <= '0;
      cmp_v_r <= 1'b0;
    end else begin
      if (cmd.capture) begin
        addr_r  <= '0;
        cmp_v_r <= 1'b0;
        if (in_data.first_pixel) begin
          fill_r <= '0;
        end
      end else if (cmd.step) begin
        cmp_v_r <= rd_en;
        if (rd_en) begin
          addr_r <= addr_r + pbff_pkg::CNT_W'(1);
        end
      end else if (cmd.finish) begin
        cmp_v_r <= 1'b0;
        if (!hit && room) begin
          fill_r <= fill_r + pbff_pkg::CNT_W'(1);
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      key_r  <= {in_data.red, in_data.green, in_data.blue};
      mbit_r <= in_data.mask_bit;
    end
    if (cmd.step) begin
      cmp_idx_r <= addr_r[pbff_pkg::ADDR_W-1:0];
    end
    if (cmd.finish) begin
      res_r <= res_nxt;
    end
  end

  assign out_data = res_r;

  a_read_filled: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.step && rd_en |-> addr_r < fill_r)
    else $error("scan reads an unfilled entry");

  a_fill_bound: assert property (@(posedge clk) disable iff (!rst_n)
    fill_r <= pbff_pkg::CNT_W'(pbff_pkg::MAX_ENTRIES))
    else $error("fill count beyond table size");

  a_fill_grows: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.finish && !hit && room |=> fill_r == $past(fill_r) + pbff_pkg::CNT_W'(1))
    else $error("new entry did not advance fill count");

endmodule
